// ----- hw/rtl/pfl_pkg.sv -----
// shared types, constants and helpers for the paraxial focal length block
`default_nettype none
package pfl_pkg;
    localparam int MAT_W = 48;
    localparam int MATRIX_FRAC_BITS_DEF = 32;
    localparam int RADIUS_W = 24;
    localparam int THICK_W = 23;
    localparam int INDEX_W = 16;
    localparam int FL_W = 32;
    localparam logic [INDEX_W-1:0] OBJECT_INDEX_RST = 16'd16384;
    localparam logic [MAT_W-1:0] QMAX = {1'b0, {(MAT_W-1){1'b1}}};
    localparam logic [1:0] REG_OBJECT_INDEX = 2'd0;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [THICK_W-1:0] thickness;
        logic [INDEX_W-1:0] index_after;
        logic [INDEX_W-1:0] index_prev;
        logic last_surface;
    } surf_t;

    localparam int SURF_W = $bits(surf_t);

    function automatic logic signed [MAT_W-1:0] sat48(input logic signed [MAT_W+1:0] v);
        logic signed [MAT_W+1:0] qm;
        begin
            qm = (MAT_W+2)'(QMAX);
            if (v > qm)
                sat48 = QMAX;
            else if (v < -qm)
                sat48 = -QMAX;
            else
                sat48 = v[MAT_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/pfl_ram.sv -----
// generic simple dual-port ram (separate write and read addresses) with registered read
`default_nettype none
module pfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pfl_front.sv -----
// input stage: tracks previous index and queues surfaces for the solver
`default_nettype none
module pfl_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [pfl_pkg::RADIUS_W-1:0] radius,
    input  wire logic [pfl_pkg::THICK_W-1:0]  thickness,
    input  wire logic [pfl_pkg::INDEX_W-1:0]  index_after,
    input  wire logic                        last_surface,
    input  wire logic [pfl_pkg::INDEX_W-1:0]  object_index,
    output      logic                        q_valid,
    input  wire logic                        q_ready,
    output      pfl_pkg::surf_t              q_data
);
    import pfl_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW = 2;

    logic [INDEX_W-1:0] prev_reg, prev_next;
    logic in_lens_reg, in_lens_next;
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic [AW:0] cnt_next;
    logic fetched_reg;
    logic push, pop;
    surf_t wdat;
    logic [SURF_W-1:0] rdat;

    assign in_ready = (cnt_reg < (AW+1)'(DEPTH));
    assign push = in_valid && in_ready;
    assign wdat.radius = radius;
    assign wdat.thickness = thickness;
    assign wdat.index_after = index_after;
    assign wdat.index_prev = in_lens_reg ? prev_reg : object_index;
    assign wdat.last_surface = last_surface;

    // read data valid in the cycle after the address settles; q_valid held until popped
    assign q_valid = fetched_reg;
    assign q_data = surf_t'(rdat);
    assign pop = q_valid && q_ready;

    pfl_ram #(.WIDTH(SURF_W), .DEPTH(DEPTH)) u_q (
        .clk(clk), .we(push), .waddr(wp_reg), .wdata(SURF_W'(wdat)),
        .raddr(rp_reg), .rdata(rdat)
    );

    always_comb
    begin
        prev_next = prev_reg;
        in_lens_next = in_lens_reg;
        if (push)
        begin
            prev_next = index_after;
            in_lens_next = !last_surface;
        end
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            in_lens_reg <= 1'b0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            fetched_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            in_lens_reg <= in_lens_next;
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
                fetched_reg <= 1'b0;
            end
            else if (!fetched_reg && cnt_reg != '0)
                fetched_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pfl_div.sv -----
// restoring divider, one quotient bit per cycle, rounds half away from zero
`default_nettype none
module pfl_div #(
    parameter int NW = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    output      logic          done,
    output      logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW+1);

    logic [NW-1:0] q_reg, d_reg;
    logic [NW:0] r_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [NW:0] r_sh;
    logic [NW:0] r_sub;
    logic [NW+1:0] rr;

    assign r_sh = {r_reg[NW-1:0], q_reg[NW-1]};
    assign r_sub = r_sh - {1'b0, d_reg};
    assign done = done_reg;
    // round: 2*rem >= den adds one
    assign rr = {r_reg, 1'b0};
    assign quo = q_reg + NW'(rr >= {2'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NW);
                q_reg <= num;
                r_reg <= '0;
                d_reg <= den;
            end
            else if (busy_reg)
            begin
                if (!r_sub[NW])
                begin
                    r_reg <= r_sub;
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pfl_back.sv -----
// matrix sequencer: power, transfer and focal length with shared divider
`default_nettype none
module pfl_back #(
    parameter int MATRIX_FRAC_BITS = pfl_pkg::MATRIX_FRAC_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    output      logic                     q_ready,
    input  wire pfl_pkg::surf_t           q_data,
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic [pfl_pkg::FL_W-1:0] efl,
    output      logic                     is_infinite,
    output      logic                     saturated
);
    import pfl_pkg::*;

    localparam int F = MATRIX_FRAC_BITS;
    localparam int NW = (F + THICK_W + 6 > 64) ? F + THICK_W + 6 : 64;
    localparam int MW = 2*MAT_W;
    localparam int HW = MAT_W/2;
    localparam logic [MAT_W-1:0] QONE = MAT_W'(64'd1 << F);

    typedef enum logic [3:0] {
        S_IDLE, S_PDIV, S_PWAIT, S_MUL1, S_ACC1, S_EDIV, S_EWAIT,
        S_MUL2, S_ACC2, S_FDIV, S_FWAIT, S_OUT
    } st_t;

    st_t st_reg;
    logic signed [MAT_W-1:0] a_reg, b_reg, c_reg, d_reg, p_reg, e_reg;
    surf_t s_reg;
    logic pneg_reg;
    logic [MW-1:0] m0_reg, m1_reg;
    logic [1:0] mph_reg;
    logic [FL_W-1:0] fl_reg;
    logic inf_reg, sat_reg;
    logic div_start;
    logic [NW-1:0] div_num, div_den, div_q;
    logic div_done;

    logic signed [RADIUS_W-1:0] rad;
    logic signed [INDEX_W+1:0] dn;
    logic [INDEX_W+1:0] dn_mag;
    logic [RADIUS_W-1:0] r_mag;
    logic [NW-1:0] q_sat;
    logic signed [MAT_W-1:0] mul_x0, mul_x1, mul_y;
    logic [MAT_W-1:0] xm0, xm1, ym;
    logic [HW-1:0] x0h, x1h, yh;
    logic [MAT_W-1:0] pp0, pp1;
    logic [5:0] msh;
    logic [MW-1:0] pm0, pm1;
    logic [MAT_W-1:0] c_mag;

    assign rad = s_reg.radius;
    assign dn = $signed({2'b0, s_reg.index_after}) - $signed({2'b0, s_reg.index_prev});
    assign dn_mag = dn[INDEX_W+1] ? (INDEX_W+2)'(0) - dn : dn;
    assign r_mag = rad[RADIUS_W-1] ? RADIUS_W'(0) - rad : rad;
    assign c_mag = c_reg[MAT_W-1] ? MAT_W'(0) - c_reg : c_reg;
    assign q_sat = (div_q > NW'(QMAX)) ? NW'(QMAX) : div_q;

    function automatic logic [MAT_W-1:0] mag48(input logic signed [MAT_W-1:0] v);
        mag48 = v[MAT_W-1] ? MAT_W'(0) - v : v;
    endfunction

    // rounded magnitude product scaled by 2^-F, saturated
    function automatic logic signed [MAT_W-1:0] fixres(input logic [MW-1:0] pr,
                                                       input logic neg);
        logic [MW:0] t;
        logic [MW:0] sh;
        logic [MAT_W-1:0] m;
        begin
            t = {1'b0, pr} + ((MW+1)'(1) << (F-1));
            sh = t >> F;
            m = (sh > (MW+1)'(QMAX)) ? QMAX : sh[MAT_W-1:0];
            fixres = neg ? MAT_W'(0) - m : m;
        end
    endfunction

    assign mul_x0 = (st_reg == S_MUL1) ? a_reg : c_reg;
    assign mul_x1 = (st_reg == S_MUL1) ? b_reg : d_reg;
    assign mul_y = (st_reg == S_MUL1) ? p_reg : e_reg;

    // one half-word partial product per cycle for each of the two products, summed over the mph_reg phases
    assign xm0 = mag48(mul_x0);
    assign xm1 = mag48(mul_x1);
    assign ym = mag48(mul_y);
    assign x0h = mph_reg[1] ? xm0[MAT_W-1:HW] : xm0[HW-1:0];
    assign x1h = mph_reg[1] ? xm1[MAT_W-1:HW] : xm1[HW-1:0];
    assign yh = mph_reg[0] ? ym[MAT_W-1:HW] : ym[HW-1:0];
    assign pp0 = MAT_W'(x0h) * MAT_W'(yh);
    assign pp1 = MAT_W'(x1h) * MAT_W'(yh);
    assign msh = (mph_reg == 2'd0) ? 6'd0 : ((mph_reg == 2'd3) ? 6'(MAT_W) : 6'(HW));
    assign pm0 = MW'(pp0) << msh;
    assign pm1 = MW'(pp1) << msh;

    logic n0_reg, n1_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        case (st_reg)
            S_PDIV:
            begin
                div_start = 1'b1;
                div_num = NW'(dn_mag) << (F-6);
                div_den = NW'(r_mag);
            end
            S_EDIV:
            begin
                div_start = 1'b1;
                div_num = NW'(s_reg.thickness) << (F+6);
                div_den = NW'(s_reg.index_after);
            end
            S_FDIV:
            begin
                div_start = 1'b1;
                div_num = NW'(1) << (F+8);
                div_den = NW'(c_mag);
            end
            default: ;
        endcase
    end

    pfl_div #(.NW(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_q)
    );

    assign q_ready = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign efl = fl_reg;
    assign is_infinite = inf_reg;
    assign saturated = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            a_reg <= QONE;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= QONE;
            p_reg <= '0;
            e_reg <= '0;
            s_reg <= '0;
            pneg_reg <= 1'b0;
            m0_reg <= '0;
            m1_reg <= '0;
            mph_reg <= '0;
            n0_reg <= 1'b0;
            n1_reg <= 1'b0;
            fl_reg <= '0;
            inf_reg <= 1'b0;
            sat_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        s_reg <= q_data;
                        st_reg <= S_PDIV;
                    end
                S_PDIV:
                begin
                    pneg_reg <= dn[INDEX_W+1] ^ rad[RADIUS_W-1];
                    if (rad == '0)
                    begin
                        p_reg <= '0;
                        st_reg <= S_MUL1;
                    end
                    else
                        st_reg <= S_PWAIT;
                end
                S_PWAIT:
                    if (div_done)
                    begin
                        p_reg <= pneg_reg ? MAT_W'(0) - q_sat[MAT_W-1:0] : q_sat[MAT_W-1:0];
                        st_reg <= S_MUL1;
                    end
                S_MUL1, S_MUL2:
                begin
                    m0_reg <= (mph_reg == 2'd0) ? pm0 : m0_reg + pm0;
                    m1_reg <= (mph_reg == 2'd0) ? pm1 : m1_reg + pm1;
                    n0_reg <= mul_x0[MAT_W-1] ^ mul_y[MAT_W-1];
                    n1_reg <= mul_x1[MAT_W-1] ^ mul_y[MAT_W-1];
                    mph_reg <= mph_reg + 2'd1;
                    if (mph_reg == 2'd3)
                        st_reg <= (st_reg == S_MUL1) ? S_ACC1 : S_ACC2;
                end
                S_ACC1:
                begin
                    c_reg <= sat48((MAT_W+2)'(fixres(m0_reg, n0_reg)) + (MAT_W+2)'(c_reg));
                    d_reg <= sat48((MAT_W+2)'(fixres(m1_reg, n1_reg)) + (MAT_W+2)'(d_reg));
                    st_reg <= s_reg.last_surface ? S_FDIV : S_EDIV;
                end
                S_EDIV:
                    if (s_reg.index_after == '0)
                    begin
                        e_reg <= QMAX;
                        st_reg <= S_MUL2;
                    end
                    else
                        st_reg <= S_EWAIT;
                S_EWAIT:
                    if (div_done)
                    begin
                        e_reg <= q_sat[MAT_W-1:0];
                        st_reg <= S_MUL2;
                    end
                S_ACC2:
                begin
                    a_reg <= sat48((MAT_W+2)'(a_reg) - (MAT_W+2)'(fixres(m0_reg, n0_reg)));
                    b_reg <= sat48((MAT_W+2)'(b_reg) - (MAT_W+2)'(fixres(m1_reg, n1_reg)));
                    st_reg <= S_IDLE;
                end
                S_FDIV:
                    if (c_reg == '0)
                    begin
                        fl_reg <= 32'h7FFFFFFF;
                        inf_reg <= 1'b1;
                        sat_reg <= 1'b0;
                        st_reg <= S_OUT;
                    end
                    else
                        st_reg <= S_FWAIT;
                S_FWAIT:
                    if (div_done)
                    begin
                        inf_reg <= 1'b0;
                        if (!c_reg[MAT_W-1])
                        begin
                            sat_reg <= div_q > NW'(32'h7FFFFFFF);
                            fl_reg <= (div_q > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                                  : div_q[FL_W-1:0];
                        end
                        else
                        begin
                            sat_reg <= div_q > NW'(32'h80000000);
                            fl_reg <= (div_q > NW'(32'h80000000)) ? 32'h80000000
                                                                  : FL_W'(0) - div_q[FL_W-1:0];
                        end
                        st_reg <= S_OUT;
                    end
                S_OUT:
                    if (out_ready)
                    begin
                        a_reg <= QONE;
                        b_reg <= '0;
                        c_reg <= '0;
                        d_reg <= QONE;
                        st_reg <= S_IDLE;
                    end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/paraxial_focal_length_top.sv -----
// top level of the paraxial focal length block
// surfaces arrive on the s_axis stream, one transfer per surface; the last
// surface of a lens (tlast) yields one transfer on m_axis with the effective
// focal length in 1/256 mm and flags for afocal and clamped results.
// the front part records the previous index and queues up to four surfaces,
// so the source can run ahead while the solver works.
// the solver handles a surface with a radius by a power division, a
// multiply into the matrix and an accumulate, then (unless it is the last
// surface) a transfer-length division with a second multiply and accumulate;
// the last surface ends with the focal length division instead. a flat
// surface skips the power division. all divisions share one radix-2 divider
// of 64 steps at the default MATRIX_FRAC_BITS.
// object_index is written through the apb port at address 0.
// reset sets the matrix to identity and object_index to 1.0, empties the queue.
// when m_axis stalls the result holds and the solver waits; the queue keeps
// accepting until full.
`default_nettype none
module paraxial_focal_length_top #(
    parameter int MATRIX_FRAC_BITS = pfl_pkg::MATRIX_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // radius, thickness, index_after, zero fill
    input  wire logic        s_axis_tlast,  // last_surface
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,  // effective focal length
    output      logic [1:0]  m_axis_tuser,  // is_infinite, saturated
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import pfl_pkg::*;

    logic [INDEX_W-1:0] obj_reg;
    logic q_valid, q_ready;
    surf_t q_data;
    logic inf, sat;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_OBJECT_INDEX) ? 32'(obj_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            obj_reg <= OBJECT_INDEX_RST;
        else if (psel && penable && pwrite && paddr == REG_OBJECT_INDEX)
            obj_reg <= pwdata[INDEX_W-1:0];
    end

    pfl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .radius(s_axis_tdata[23:0]), .thickness(s_axis_tdata[46:24]),
        .index_after(s_axis_tdata[62:47]), .last_surface(s_axis_tlast),
        .object_index(obj_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    pfl_back #(.MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .efl(m_axis_tdata), .is_infinite(inf), .saturated(sat)
    );

    assign m_axis_tuser = {sat, inf};
endmodule
`default_nettype wire

// ----- bench/tb_paraxial_focal_length_top.sv -----
// testbench for the paraxial focal length block: directed table, random lenses, live predictor
`timescale 1ns / 100ps
module tb_paraxial_focal_length_top;
    import pfl_pkg::*;

    localparam longint QMAX_L = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint QONE_L = 64'h0000_0001_0000_0000;
    localparam int QFRAC = MATRIX_FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic signed [FL_W-1:0] focal;
        logic                   afocal;
        logic                   clamped;
    } focal_t;

    typedef struct {
        logic signed [RADIUS_W-1:0] radius;
        logic [THICK_W-1:0]         thick;
        logic [INDEX_W-1:0]         index_after;
        logic                       last;
        bit                         typed;
        logic signed [FL_W-1:0]     focal;
        logic                       afocal;
        logic                       clamped;
    } surf_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // radius, thickness, index_after, zero fill
    logic        s_axis_tlast;   // last_surface
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // effective focal length
    logic [1:0]  m_axis_tuser;   // is_infinite, saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    paraxial_focal_length_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [INDEX_W-1:0] obj_index;
    logic [INDEX_W-1:0] last_index;
    bit                 mid_lens;
    longint             ma, mb, mc, md;

    focal_t focal_q[$];
    int     errors;
    int     idle_pct;
    int     stall_pct;
    int     hold_left;
    int     quiet_cycles;
    int     n_sent;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp48(longint v);
        if (v > QMAX_L)
            return QMAX_L;
        if (v < -QMAX_L)
            return -QMAX_L;
        return v;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint unsigned un, ud, q;
        un = magnitude(num);
        ud = magnitude(den);
        q = (un + ud / 2) / ud;
        if (q > QMAX_L)
            q = QMAX_L;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        logic [127:0] pr;
        longint unsigned res;
        pr = 128'(magnitude(a)) * 128'(magnitude(b)) + (128'd1 << (QFRAC - 1));
        pr = pr >> QFRAC;
        if (pr > 128'(QMAX_L))
            res = QMAX_L;
        else
            res = pr[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(res) : longint'(res);
    endfunction

    task automatic restart_lens();
        ma = QONE_L;
        mb = 0;
        mc = 0;
        md = QONE_L;
        last_index = obj_index;
        mid_lens = 0;
    endtask

    task automatic trace_surface(input logic signed [RADIUS_W-1:0] radius,
                                 input logic [THICK_W-1:0] thick,
                                 input logic [INDEX_W-1:0] n_after,
                                 input logic last);
        longint             pw, el, dn;
        longint unsigned    num, q1, r1, ev, uc, q;
        logic [INDEX_W-1:0] n_prev;
        focal_t             fr;
        n_prev = mid_lens ? last_index : obj_index;
        pw = 0;
        if (radius != 0)
        begin
            dn = longint'(n_after) - longint'(n_prev);
            pw = round_div(dn * (64'sd1 <<< (QFRAC - 6)), longint'(radius));
        end
        mc = clamp48(fix_mul(ma, pw) + mc);
        md = clamp48(fix_mul(mb, pw) + md);
        if (!last)
        begin
            if (n_after == 0)
                el = QMAX_L;
            else
            begin
                num = longint'(thick) << 6;
                q1 = num / n_after;
                r1 = num % n_after;
                if (q1 > (QMAX_L >> QFRAC))
                    el = QMAX_L;
                else
                begin
                    ev = (q1 << QFRAC) + ((r1 << QFRAC) + n_after / 2) / n_after;
                    el = ev > QMAX_L ? QMAX_L : longint'(ev);
                end
            end
            ma = clamp48(ma - fix_mul(mc, el));
            mb = clamp48(mb - fix_mul(md, el));
            last_index = n_after;
            mid_lens = 1;
        end
        else
        begin
            fr.focal = 32'h7FFF_FFFF;
            fr.afocal = (mc == 0);
            fr.clamped = 0;
            if (mc != 0)
            begin
                uc = magnitude(mc);
                q = ((64'd1 << (QFRAC + 8)) + uc / 2) / uc;
                if (mc > 0)
                begin
                    if (q > 64'h7FFF_FFFF)
                    begin
                        q = 64'h7FFF_FFFF;
                        fr.clamped = 1;
                    end
                    fr.focal = q[31:0];
                end
                else
                begin
                    if (q > 64'h8000_0000)
                    begin
                        q = 64'h8000_0000;
                        fr.clamped = 1;
                    end
                    fr.focal = -q[31:0];
                end
            end
            focal_q.push_back(fr);
            restart_lens();
        end
    endtask

    // one surface onto the input stream, with random gaps
    task automatic send_surface(input logic signed [RADIUS_W-1:0] radius,
                                input logic [THICK_W-1:0] thick,
                                input logic [INDEX_W-1:0] n_after,
                                input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, n_after, thick, radius};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        trace_surface(radius, thick, n_after, last);
        n_sent++;
    endtask

    task automatic write_object_index(input logic [INDEX_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_OBJECT_INDEX;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        obj_index = value;
        restart_lens();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (focal_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_lens();
        int                         nsurf;
        logic signed [RADIUS_W-1:0] r;
        logic [THICK_W-1:0]         t;
        logic [INDEX_W-1:0]         n;
        int                         pick;
        nsurf = ($urandom_range(19) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
        for (int k = 0; k < nsurf; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                r = '0;
            else if (pick < 75)
                r = RADIUS_W'($signed($urandom_range(40000)) - 20000);
            else
                r = RADIUS_W'($urandom);
            t = ($urandom_range(99) < 70) ? THICK_W'($urandom_range(5000)) : THICK_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 85)
                n = INDEX_W'($urandom_range(65535, 16384));
            else if (pick < 95)
                n = INDEX_W'($urandom);
            else
                n = '0;
            send_surface(r, t, n, k == nsurf - 1);
        end
    endtask

    surf_row_t directed[] = '{
        // flat single surface: afocal
        '{24'sd0, 23'd0, 16'd16384, 1'b1, 1, 32'h7FFF_FFFF, 1'b1, 1'b0},
        // weakest positive power: clamped high
        '{24'sh7FFFFF, 23'd0, 16'd16385, 1'b1, 1, 32'h7FFF_FFFF, 1'b0, 1'b1},
        // weakest negative power: clamped low
        '{24'sh800000, 23'd0, 16'd16385, 1'b1, 1, 32'h8000_0000, 1'b0, 1'b1},
        '{24'sd1, 23'd0, 16'd65535, 1'b1, 0, 0, 0, 0},
        '{-24'sd1, 23'd0, 16'd65535, 1'b1, 0, 0, 0, 0},
        '{24'sd12800, 23'd1280, 16'd24576, 1'b0, 0, 0, 0, 0},
        '{-24'sd12800, 23'd0, 16'd16384, 1'b1, 0, 0, 0, 0},
        '{24'sd5000, 23'h7FFFFF, 16'd65535, 1'b0, 0, 0, 0, 0},
        '{24'sd0, 23'd256, 16'd16384, 1'b1, 0, 0, 0, 0},
        // zero index after a surface
        '{24'sd2560, 23'd512, 16'd0, 1'b0, 0, 0, 0, 0},
        '{-24'sd2560, 23'd0, 16'd16384, 1'b1, 0, 0, 0, 0},
        // index below 1.0
        '{24'sd2560, 23'd300, 16'd100, 1'b0, 0, 0, 0, 0},
        '{24'sd0, 23'd0, 16'd16384, 1'b1, 0, 0, 0, 0},
        '{24'sh7FFFFF, 23'h7FFFFF, 16'd65535, 1'b0, 0, 0, 0, 0},
        '{24'sh800000, 23'h7FFFFF, 16'd16384, 1'b0, 0, 0, 0, 0},
        '{24'sd64, 23'd0, 16'd65535, 1'b1, 0, 0, 0, 0},
        '{24'sd3000, 23'd2000, 16'd26000, 1'b0, 0, 0, 0, 0},
        '{24'sd0, 23'd6000, 16'd16384, 1'b0, 0, 0, 0, 0},
        '{-24'sd4000, 23'd1500, 16'd27000, 1'b0, 0, 0, 0, 0},
        '{24'sd9000, 23'd0, 16'd16384, 1'b1, 0, 0, 0, 0}
    };

    // output side: stalls, result check, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (focal_q.size() == 0)
                begin
                    $error("unexpected result transfer: efl %0d", $signed(m_axis_tdata));
                    errors++;
                end
                else
                begin
                    focal_t ex;
                    ex = focal_q.pop_front();
                    if (m_axis_tdata !== ex.focal)
                    begin
                        $error("efl: expected %0d, actual %0d",
                               ex.focal, $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tuser[0] !== ex.afocal)
                    begin
                        $error("is_infinite: expected %0b, actual %0b", ex.afocal, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== ex.clamped)
                    begin
                        $error("saturated: expected %0b, actual %0b", ex.clamped, m_axis_tuser[1]);
                        errors++;
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        logic [INDEX_W-1:0] settings[4];
        int                 idle_set[4];
        int                 stall_set[4];
        int                 stop_at;
        focal_t             ex;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        n_sent = 0;
        obj_index = OBJECT_INDEX_RST;
        restart_lens();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].typed)
            begin
                send_surface(directed[i].radius, directed[i].thick,
                             directed[i].index_after, directed[i].last);
                ex = focal_q[$];
                if (ex.focal !== directed[i].focal || ex.afocal !== directed[i].afocal
                    || ex.clamped !== directed[i].clamped)
                begin
                    focal_q.delete(focal_q.size() - 1);
                    ex.focal = directed[i].focal;
                    ex.afocal = directed[i].afocal;
                    ex.clamped = directed[i].clamped;
                    focal_q.push_back(ex);
                end
            end
            else
                send_surface(directed[i].radius, directed[i].thick,
                             directed[i].index_after, directed[i].last);
        end
        drain();

        settings = '{16'd65535, 16'd16384, 16'(($urandom_range(65535, 16384))), 16'd24576};
        idle_set = '{0, 76, 0, 20};
        stall_set = '{0, 0, 76, 20};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_object_index(settings[ph]);
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                hold_left = 3000;
            stop_at = n_sent + 180;
            while (n_sent < stop_at)
                random_lens();
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
